>>> sv/dwtb_pkg.sv
// ============================================================================
// dwtb_pkg
// Shared types and fixed widths for the distance weighted tile blend core.
// ============================================================================
`default_nettype none

package dwtb_pkg;

    localparam int NEIGHBOR_COUNT = 4;
    localparam int COORD_BITS     = 13;
    localparam int TILES          = NEIGHBOR_COUNT + 1;
    localparam int CHANNELS       = 3;
    localparam int LANES          = TILES * CHANNELS;

    // register indexes on the write port
    localparam logic [2:0] REG_TILE_HEIGHT      = 3'd0;
    localparam logic [2:0] REG_TILE_WIDTH       = 3'd1;
    localparam logic [2:0] REG_MAX_DISTANCE     = 3'd2;
    localparam logic [2:0] REG_MAIN_WEIGHT      = 3'd3;
    localparam logic [2:0] REG_NEIGHBOR_WEIGHTS = 3'd4;
    localparam logic [2:0] REG_NEIGHBOR_OFFSETS = 3'd5;

    // datapath widths
    localparam int SIZE_W   = 14;              // tile size / doubled coordinate
    localparam int CTR_W    = 17;              // signed centre in half pixels
    localparam int DIFF_W   = 18;              // signed distance component
    localparam int SQ_W     = 32;              // one squared component
    localparam int SSQ_W    = 33;              // squared distance
    localparam int RAD_W    = SSQ_W + 16;      // radicand, Q.16
    localparam int ROOT_W   = (RAD_W + 1) / 2; // distance, Q.8
    localparam int LIM_W    = 23;              // 2*max_distance in Q.8
    localparam int WT_W     = 16;
    localparam int INF_W    = WT_W + LIM_W;
    localparam int ISUM_W   = INF_W + 3;
    localparam int PIX_W    = 8;
    localparam int NUM_W    = PIX_W + INF_W;
    localparam int COLOR_W  = 24;

    localparam int FRONT_STAGES = 3;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = PIX_W;
    localparam int SIDE_A_DEPTH = FRONT_STAGES + SQRT_STAGES + 2;
    localparam int PIPE_LATENCY = SIDE_A_DEPTH + 1 + DIV_STAGES + 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_row;
        logic [COORD_BITS-1:0] pixel_col;
        logic [COLOR_W-1:0]    main_color;
        logic [COLOR_W-1:0]    neighbor_color_0;
        logic [COLOR_W-1:0]    neighbor_color_1;
        logic [COLOR_W-1:0]    neighbor_color_2;
        logic [COLOR_W-1:0]    neighbor_color_3;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] blended_color;
        logic               at_center;
        logic               no_influence;
    } result_t;

endpackage

`default_nettype wire

>>> sv/dwtb_delay.sv
// ============================================================================
// dwtb_delay
// Fixed-length shift line for side data that rides alongside the datapath.
// ============================================================================
`default_nettype none

module dwtb_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> sv/dwtb_isqrt.sv
// ============================================================================
// dwtb_isqrt
// Pipelined integer square root, one root bit per stage, several lanes.
// ============================================================================
`default_nettype none

module dwtb_isqrt #(
    parameter int IN_BITS = 49,
    parameter int LANES   = 5
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [IN_BITS-1:0]           rad [LANES],
    output logic                              out_valid,
    output logic [(IN_BITS+1)/2-1:0]          root [LANES]
);

    localparam int ROOT_BITS = (IN_BITS + 1) / 2;
    localparam int W         = 2 * ROOT_BITS;

    logic         vld_reg  [ROOT_BITS];
    logic [W-1:0] rem_reg  [ROOT_BITS][LANES];
    logic [W-1:0] res_reg  [ROOT_BITS][LANES];
    logic [W-1:0] rem_next [ROOT_BITS][LANES];
    logic [W-1:0] res_next [ROOT_BITS][LANES];
    logic         vld_prev [ROOT_BITS];

    always_comb
    begin
        logic [W-1:0] bitv;
        logic [W-1:0] rem_p;
        logic [W-1:0] res_p;
        logic [W-1:0] trial;
        for (int j = 0; j < ROOT_BITS; j++)
        begin
            bitv = W'(1) << (2 * (ROOT_BITS - 1 - j));
            vld_prev[j] = (j == 0) ? in_valid : vld_reg[(j == 0) ? 0 : j-1];
            for (int l = 0; l < LANES; l++)
            begin
                if (j == 0)
                begin
                    rem_p = W'(rad[l]);
                    res_p = '0;
                end
                else
                begin
                    rem_p = rem_reg[j-1][l];
                    res_p = res_reg[j-1][l];
                end
                trial = res_p + bitv;
                if (rem_p >= trial)
                begin
                    rem_next[j][l] = rem_p - trial;
                    res_next[j][l] = (res_p >> 1) + bitv;
                end
                else
                begin
                    rem_next[j][l] = rem_p;
                    res_next[j][l] = res_p >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ROOT_BITS; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j < ROOT_BITS; j++)
            begin
                vld_reg[j] <= vld_prev[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ROOT_BITS; j++)
        begin
            if (vld_prev[j])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[j][l] <= rem_next[j][l];
                    res_reg[j][l] <= res_next[j][l];
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_BITS-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root[l] = res_reg[ROOT_BITS-1][l][ROOT_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/dwtb_div.sv
// ============================================================================
// dwtb_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ============================================================================
`default_nettype none

module dwtb_div #(
    parameter int NUM_BITS = 47,
    parameter int DEN_BITS = 42,
    parameter int Q_BITS   = 8,
    parameter int LANES    = 15
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [NUM_BITS-1:0] num [LANES],
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     out_valid,
    output logic [Q_BITS-1:0]        quo [LANES]
);

    // quotient is known to fit Q_BITS, so the remainder never exceeds W bits
    localparam int W = DEN_BITS + Q_BITS;

    logic                vld_reg  [Q_BITS];
    logic [DEN_BITS-1:0] den_reg  [Q_BITS];
    logic [W-1:0]        rem_reg  [Q_BITS][LANES];
    logic [Q_BITS-1:0]   q_reg    [Q_BITS][LANES];
    logic [W-1:0]        rem_next [Q_BITS][LANES];
    logic [Q_BITS-1:0]   q_next   [Q_BITS][LANES];
    logic [DEN_BITS-1:0] den_prev [Q_BITS];
    logic                vld_prev [Q_BITS];

    always_comb
    begin
        logic [W-1:0]      dsh;
        logic [W-1:0]      rem_p;
        logic [Q_BITS-1:0] q_p;
        for (int j = 0; j < Q_BITS; j++)
        begin
            vld_prev[j] = (j == 0) ? in_valid : vld_reg[(j == 0) ? 0 : j-1];
            den_prev[j] = (j == 0) ? den : den_reg[(j == 0) ? 0 : j-1];
            dsh = W'(den_prev[j]) << (Q_BITS - 1 - j);
            for (int l = 0; l < LANES; l++)
            begin
                if (j == 0)
                begin
                    rem_p = W'(num[l]);
                    q_p   = '0;
                end
                else
                begin
                    rem_p = rem_reg[j-1][l];
                    q_p   = q_reg[j-1][l];
                end
                if (rem_p >= dsh)
                begin
                    rem_next[j][l] = rem_p - dsh;
                    q_next[j][l]   = q_p | (Q_BITS'(1) << (Q_BITS - 1 - j));
                end
                else
                begin
                    rem_next[j][l] = rem_p;
                    q_next[j][l]   = q_p;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < Q_BITS; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j < Q_BITS; j++)
            begin
                vld_reg[j] <= vld_prev[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < Q_BITS; j++)
        begin
            if (vld_prev[j])
            begin
                den_reg[j] <= den_prev[j];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[j][l] <= rem_next[j][l];
                    q_reg[j][l]   <= q_next[j][l];
                end
            end
        end
    end

    assign out_valid = vld_reg[Q_BITS-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = q_reg[Q_BITS-1][l];
        end
    end

endmodule

`default_nettype wire

>>> sv/distance_weighted_tile_blend_core.sv
// ============================================================================
// distance_weighted_tile_blend_core
// Blends main and neighbour tile colours by weighted linear distance falloff.
// ============================================================================
//  channel   | ports                          | beat marked by
//  ----------+--------------------------------+-------------------------
//  item in   | item                           | start && !busy
//  result    | result                         | done (one cycle)
//  config    | wr_index, wr_data              | wr_en
//
//  One item per cycle; results come out in the order of their items.
//  The depth is mostly set by the 25-stage square root and 8-stage divider.
//  busy stays low: the pipeline always advances and the receiver cannot stall.
//  Reset clears the valid bits and loads the register defaults.
// ============================================================================
`default_nettype none

module distance_weighted_tile_blend_core
    import dwtb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             done,
    output result_t          result,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [63:0] wr_data
);

    localparam logic [1:0] OFS_ZERO   = 2'd0;
    localparam logic [1:0] OFS_PLUS   = 2'd1;
    localparam logic [1:0] OFS_MINUS2 = 2'd2;
    localparam logic [1:0] OFS_MINUS1 = 2'd3;

    localparam int SIDE_A_W = TILES * COLOR_W + 1;
    localparam int SIDE_B_W = COLOR_W + 2;

    // ------------------------------------------------------------------
    // configuration
    logic [SIZE_W-1:0]            tile_height_reg;
    logic [SIZE_W-1:0]            tile_width_reg;
    logic [SIZE_W-1:0]            max_distance_reg;
    logic [WT_W-1:0]              main_weight_reg;
    logic [WT_W*4-1:0]            neighbor_weights_reg;
    logic [15:0]                  neighbor_offsets_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_height_reg      <= SIZE_W'(4096);
            tile_width_reg       <= SIZE_W'(4096);
            max_distance_reg     <= SIZE_W'(5792);
            main_weight_reg      <= WT_W'(4096);
            neighbor_weights_reg <= '0;
            neighbor_offsets_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TILE_HEIGHT:      tile_height_reg      <= wr_data[SIZE_W-1:0];
                REG_TILE_WIDTH:       tile_width_reg       <= wr_data[SIZE_W-1:0];
                REG_MAX_DISTANCE:     max_distance_reg     <= wr_data[SIZE_W-1:0];
                REG_MAIN_WEIGHT:      main_weight_reg      <= wr_data[WT_W-1:0];
                REG_NEIGHBOR_WEIGHTS: neighbor_weights_reg <= wr_data;
                REG_NEIGHBOR_OFFSETS: neighbor_offsets_reg <= wr_data[15:0];
                default:              ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // centre in half pixels for an offset code: size * (1 + 2*offset)
    function automatic logic signed [CTR_W-1:0] centre2(input logic [SIZE_W-1:0] size,
                                                        input logic [1:0] code);
        logic signed [CTR_W-1:0] s1;
        logic signed [CTR_W-1:0] s3;
        s1 = signed'(CTR_W'(size));
        s3 = s1 + (s1 <<< 1);
        unique case (code)
            OFS_ZERO:   centre2 = s1;
            OFS_PLUS:   centre2 = s3;
            OFS_MINUS2: centre2 = -s3;
            OFS_MINUS1: centre2 = -s1;
            default:    centre2 = s1;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stage 1: distance components per tile
    logic [SIZE_W-1:0]        row2;
    logic [SIZE_W-1:0]        col2;
    logic                     centre_hit;
    logic signed [DIFF_W-1:0] dy_next [TILES];
    logic signed [DIFF_W-1:0] dx_next [TILES];
    logic signed [DIFF_W-1:0] dy_reg  [TILES];
    logic signed [DIFF_W-1:0] dx_reg  [TILES];
    logic                     vld1_reg;

    assign row2       = {item.pixel_row, 1'b0};
    assign col2       = {item.pixel_col, 1'b0};
    assign centre_hit = (row2 == tile_height_reg) && (col2 == tile_width_reg);

    always_comb
    begin
        logic [1:0]              xc;
        logic [1:0]              yc;
        logic signed [CTR_W-1:0] cy;
        logic signed [CTR_W-1:0] cx;
        for (int t = 0; t < TILES; t++)
        begin
            if (t == 0)
            begin
                xc = OFS_ZERO;
                yc = OFS_ZERO;
            end
            else
            begin
                xc = neighbor_offsets_reg[4*(t-1) +: 2];
                yc = neighbor_offsets_reg[4*(t-1)+2 +: 2];
            end
            cy = centre2(tile_height_reg, yc);
            cx = centre2(tile_width_reg, xc);
            dy_next[t] = signed'(DIFF_W'(row2)) - signed'({cy[CTR_W-1], cy});
            dx_next[t] = signed'(DIFF_W'(col2)) - signed'({cx[CTR_W-1], cx});
        end
    end

    // stage 2: squares
    logic [SQ_W-1:0] sqy_next [TILES];
    logic [SQ_W-1:0] sqx_next [TILES];
    logic [SQ_W-1:0] sqy_reg  [TILES];
    logic [SQ_W-1:0] sqx_reg  [TILES];
    logic            vld2_reg;

    always_comb
    begin
        logic signed [2*DIFF_W-1:0] py;
        logic signed [2*DIFF_W-1:0] px;
        for (int t = 0; t < TILES; t++)
        begin
            py = dy_reg[t] * dy_reg[t];
            px = dx_reg[t] * dx_reg[t];
            sqy_next[t] = py[SQ_W-1:0];
            sqx_next[t] = px[SQ_W-1:0];
        end
    end

    // stage 3: squared distance
    logic [SSQ_W-1:0] ssq_reg [TILES];
    logic             vld3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= accept;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < TILES; t++)
        begin
            if (accept)
            begin
                dy_reg[t] <= dy_next[t];
                dx_reg[t] <= dx_next[t];
            end
            if (vld1_reg)
            begin
                sqy_reg[t] <= sqy_next[t];
                sqx_reg[t] <= sqx_next[t];
            end
            if (vld2_reg)
            begin
                ssq_reg[t] <= SSQ_W'(sqy_reg[t]) + SSQ_W'(sqx_reg[t]);
            end
        end
    end

    // ------------------------------------------------------------------
    // square root of squared distance in Q.16 gives distance in Q.8
    logic [RAD_W-1:0]  rad  [TILES];
    logic [ROOT_W-1:0] root [TILES];
    logic              root_vld;

    always_comb
    begin
        for (int t = 0; t < TILES; t++)
        begin
            rad[t] = {ssq_reg[t], 16'b0};
        end
    end

    dwtb_isqrt #(
        .IN_BITS (RAD_W),
        .LANES   (TILES)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld3_reg),
        .rad       (rad),
        .out_valid (root_vld),
        .root      (root)
    );

    // ------------------------------------------------------------------
    // falloff, influence, influence sum and numerators
    logic [LIM_W-1:0]  lim;
    logic [WT_W-1:0]   wt_sel   [TILES];
    logic [LIM_W-1:0]  fall_reg [TILES];
    logic [INF_W-1:0]  infl_reg [TILES];
    logic [NUM_W-1:0]  num_next [LANES];
    logic [NUM_W-1:0]  num_reg  [LANES];
    logic [ISUM_W-1:0] isum_next;
    logic [ISUM_W-1:0] isum_reg;
    logic              fall_vld_reg;
    logic              infl_vld_reg;
    logic              num_vld_reg;
    logic [SIDE_A_W-1:0] side_a_in;
    logic [SIDE_A_W-1:0] side_a_out;
    logic [SIDE_B_W-1:0] side_b_next;
    logic [SIDE_B_W-1:0] side_b_reg;
    logic [SIDE_B_W-1:0] side_b_out;

    assign lim = {max_distance_reg, 9'b0};

    always_comb
    begin
        for (int t = 0; t < TILES; t++)
        begin
            wt_sel[t] = (t == 0) ? main_weight_reg
                                 : neighbor_weights_reg[WT_W*((t == 0) ? 0 : t-1) +: WT_W];
        end
    end

    assign side_a_in = {centre_hit,
                        item.neighbor_color_3, item.neighbor_color_2,
                        item.neighbor_color_1, item.neighbor_color_0,
                        item.main_color};

    dwtb_delay #(
        .WIDTH (SIDE_A_W),
        .DEPTH (SIDE_A_DEPTH)
    ) u_side_a (
        .clk  (clk),
        .din  (side_a_in),
        .dout (side_a_out)
    );

    always_comb
    begin
        logic [COLOR_W-1:0] col;
        isum_next = '0;
        for (int t = 0; t < TILES; t++)
        begin
            isum_next = isum_next + ISUM_W'(infl_reg[t]);
            col = side_a_out[COLOR_W*t +: COLOR_W];
            for (int c = 0; c < CHANNELS; c++)
            begin
                num_next[t*CHANNELS+c] = NUM_W'(col[PIX_W*c +: PIX_W]) * NUM_W'(infl_reg[t]);
            end
        end
        side_b_next = {side_a_out[SIDE_A_W-1], (isum_next == '0), side_a_out[COLOR_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fall_vld_reg <= 1'b0;
            infl_vld_reg <= 1'b0;
            num_vld_reg  <= 1'b0;
        end
        else
        begin
            fall_vld_reg <= root_vld;
            infl_vld_reg <= fall_vld_reg;
            num_vld_reg  <= infl_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < TILES; t++)
        begin
            if (root_vld)
            begin
                if ({2'b0, lim} <= root[t])
                begin
                    fall_reg[t] <= '0;
                end
                else
                begin
                    fall_reg[t] <= lim - root[t][LIM_W-1:0];
                end
            end
            if (fall_vld_reg)
            begin
                infl_reg[t] <= INF_W'(wt_sel[t]) * INF_W'(fall_reg[t]);
            end
        end
        if (infl_vld_reg)
        begin
            isum_reg   <= isum_next;
            side_b_reg <= side_b_next;
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[l] <= num_next[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // normalising division
    logic [PIX_W-1:0] quo [LANES];
    logic             quo_vld;

    dwtb_div #(
        .NUM_BITS (NUM_W),
        .DEN_BITS (ISUM_W),
        .Q_BITS   (PIX_W),
        .LANES    (LANES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_vld_reg),
        .num       (num_reg),
        .den       (isum_reg),
        .out_valid (quo_vld),
        .quo       (quo)
    );

    dwtb_delay #(
        .WIDTH (SIDE_B_W),
        .DEPTH (DIV_STAGES)
    ) u_side_b (
        .clk  (clk),
        .din  (side_b_reg),
        .dout (side_b_out)
    );

    // ------------------------------------------------------------------
    // channel accumulation and result register
    result_t result_next;
    result_t result_reg;
    logic    done_reg;

    always_comb
    begin
        logic [PIX_W-1:0]   acc;
        logic [COLOR_W-1:0] blend;
        for (int c = 0; c < CHANNELS; c++)
        begin
            acc = '0;
            for (int t = 0; t < TILES; t++)
            begin
                acc = acc + quo[t*CHANNELS+c];
            end
            blend[PIX_W*c +: PIX_W] = acc;
        end
        priority if (side_b_out[SIDE_B_W-1])
        begin
            result_next.blended_color = side_b_out[COLOR_W-1:0];
            result_next.at_center     = 1'b1;
            result_next.no_influence  = 1'b0;
        end
        else if (side_b_out[COLOR_W])
        begin
            result_next.blended_color = '0;
            result_next.at_center     = 1'b0;
            result_next.no_influence  = 1'b1;
        end
        else
        begin
            result_next.blended_color = blend;
            result_next.at_center     = 1'b0;
            result_next.no_influence  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= quo_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quo_vld)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> sv/dwtb_checker.sv
// ============================================================================
// dwtb_checker
// Port-level checks for the tile blend core, bound to the top level.
// ============================================================================
`default_nettype none

module dwtb_checker
    import dwtb_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // every accepted beat comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("result missing after accepted beat");

    // no result without a beat accepted one latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without matching input beat");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.at_center && result.no_influence))
        else $error("centre and no-influence flags both set");

    a_black_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.no_influence) |-> (result.blended_color == '0))
        else $error("no-influence result is not black");

endmodule

bind distance_weighted_tile_blend_core dwtb_checker u_dwtb_checker (.*);

`default_nettype wire
